/* rtl/core/spmlq_pkg.sv */
// shared types for the strict priority multilevel queue
// no dependencies; imported by spmlq_ctrl, spmlq_dp and the top level
package spmlq_pkg;

    typedef enum logic [1:0] {
        REQ_ADD = 2'd0,
        REQ_GET = 2'd1,
        REQ_PUT = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic {
        CS_IDLE   = 1'b0,
        CS_ACCESS = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } spmlq_cmd_t;

endpackage

/* rtl/core/spmlq_ctrl.sv */
// sequencer for the strict priority multilevel queue
// depends on spmlq_pkg; drives the load and exec commands of spmlq_dp
module spmlq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output spmlq_pkg::spmlq_cmd_t cmd
);
    import spmlq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    state_next = CS_ACCESS;
                end
            end
            CS_ACCESS:
            begin
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy     = 1'b0;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                cmd.load = start;
            end
            CS_ACCESS:
            begin
                busy     = 1'b1;
                cmd.exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/spmlq_dp.sv */
// datapath: level bitmap, per-level head/count memory, fifo store, running bitmap
// depends on spmlq_pkg; steered by spmlq_ctrl
module spmlq_dp #(
    parameter int NUM_LEVELS  = 140,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_COUNT    = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  spmlq_pkg::spmlq_cmd_t cmd,
    input  logic [1:0]            req_type,
    input  logic [7:0]            proc_id,
    input  logic [7:0]            level,
    output logic                  done,
    output logic [7:0]            granted_id,
    output logic [7:0]            granted_level,
    output logic [1:0]            status
);
    import spmlq_pkg::*;

    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SD = NUM_LEVELS * QUEUE_DEPTH;
    localparam int SW = $clog2(SD);
    localparam int IW = $clog2(ID_COUNT);

    logic [HW-1:0]         head_mem [NUM_LEVELS];
    logic [CW-1:0]         cnt_mem  [NUM_LEVELS];
    logic [7:0]            store_mem [SD];

    logic [NUM_LEVELS-1:0] nonempty_reg;
    logic [ID_COUNT-1:0]   running_reg;

    logic [1:0]            req_reg;
    logic [7:0]            id_reg;
    logic [LW-1:0]         sel_reg;
    logic                  range_bad_reg;
    logic                  found_reg;
    logic [HW-1:0]         head_q;
    logic [CW-1:0]         cnt_q;
    logic [7:0]            store_q;

    logic                  done_reg;
    logic                  get_ok_reg;
    logic [1:0]            status_reg;
    logic [LW-1:0]         glvl_reg;

    // accept-side signals
    logic [NUM_LEVELS-1:0] iso;
    logic [LW-1:0]         enc;
    logic                  in_push;
    logic                  in_range_bad;
    logic [LW-1:0]         sel_next;

    // access-side signals
    logic                  ne_sel;
    logic [HW-1:0]         head;
    logic [CW-1:0]         cnt;
    logic                  full;
    logic [CW:0]           pos_sum;
    logic [HW-1:0]         pos;
    logic [HW-1:0]         head_inc;
    logic                  is_push;
    logic                  is_get;
    logic                  push_ok;
    logic                  get_ok;
    logic [1:0]            status_next;
    logic [SW-1:0]         store_addr;

    // lowest set bit of the nonempty bitmap is the highest ready priority
    always_comb
    begin
        iso = nonempty_reg & (~nonempty_reg + NUM_LEVELS'(1));
        enc = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (iso[i])
            begin
                enc = enc | LW'(i);
            end
        end
    end

    always_comb
    begin
        in_push      = (req_type == REQ_ADD) || (req_type == REQ_PUT);
        in_range_bad = in_push && ({1'b0, level} >= 9'(NUM_LEVELS));
        if (req_type == REQ_GET)
        begin
            sel_next = enc;
        end
        else if (in_push && !in_range_bad)
        begin
            sel_next = level[LW-1:0];
        end
        else
        begin
            sel_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg       <= req_type;
            id_reg        <= proc_id;
            sel_reg       <= sel_next;
            range_bad_reg <= in_range_bad;
            found_reg     <= |nonempty_reg;
        end
    end

    // an empty level reads as head zero, count zero
    always_comb
    begin
        ne_sel   = nonempty_reg[sel_reg];
        head     = ne_sel ? head_q : '0;
        cnt      = ne_sel ? cnt_q : '0;
        full     = (cnt == CW'(QUEUE_DEPTH));
        pos_sum  = (CW + 1)'(head) + (CW + 1)'(cnt);
        if (pos_sum >= (CW + 1)'(QUEUE_DEPTH))
        begin
            pos = HW'(pos_sum - (CW + 1)'(QUEUE_DEPTH));
        end
        else
        begin
            pos = HW'(pos_sum);
        end
        head_inc = (head == HW'(QUEUE_DEPTH - 1)) ? '0 : head + HW'(1);
        is_push  = (req_reg == REQ_ADD) || (req_reg == REQ_PUT);
        is_get   = (req_reg == REQ_GET);
        push_ok  = is_push && !range_bad_reg && !full;
        get_ok   = is_get && found_reg;
        store_addr = SW'(sel_reg) * SW'(QUEUE_DEPTH) + SW'(is_get ? head : pos);
    end

    always_comb
    begin
        status_next = ST_OK;
        priority if (is_push && range_bad_reg)
        begin
            status_next = ST_RANGE;
        end
        else if (is_push && full)
        begin
            status_next = ST_FULL;
        end
        else if (is_get && !found_reg)
        begin
            status_next = ST_NONE;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    // per-level head and count
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            head_q <= head_mem[sel_next];
            cnt_q  <= cnt_mem[sel_next];
        end
        if (cmd.exec && push_ok)
        begin
            head_mem[sel_reg] <= head;
            cnt_mem[sel_reg]  <= cnt + CW'(1);
        end
        else if (cmd.exec && get_ok)
        begin
            head_mem[sel_reg] <= head_inc;
            cnt_mem[sel_reg]  <= cnt - CW'(1);
        end
    end

    // fifo entries of all levels
    always_ff @(posedge clk)
    begin
        if (cmd.exec && push_ok)
        begin
            store_mem[store_addr] <= id_reg;
        end
        if (cmd.exec && get_ok)
        begin
            store_q <= store_mem[store_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg <= '0;
            running_reg  <= '0;
            done_reg     <= 1'b0;
            get_ok_reg   <= 1'b0;
            status_reg   <= ST_OK;
            glvl_reg     <= '0;
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cmd.exec)
            begin
                get_ok_reg <= get_ok;
                status_reg <= status_next;
                glvl_reg   <= get_ok ? sel_reg : '0;
                if (push_ok)
                begin
                    nonempty_reg[sel_reg] <= 1'b1;
                end
                else if (get_ok)
                begin
                    nonempty_reg[sel_reg] <= (cnt != CW'(1));
                end
                if ((req_reg == REQ_PUT) && ({1'b0, id_reg} < 9'(ID_COUNT)))
                begin
                    running_reg[id_reg[IW-1:0]] <= 1'b0;
                end
            end
            // granted process marked running in its result beat
            if (done_reg && get_ok_reg && ({1'b0, store_q} < 9'(ID_COUNT)))
            begin
                running_reg[store_q[IW-1:0]] <= 1'b1;
            end
        end
    end

    assign done          = done_reg;
    assign granted_id    = get_ok_reg ? store_q : 8'd0;
    assign granted_level = 8'(glvl_reg);
    assign status        = status_reg;

`ifndef SYNTH
    a_exec_done : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> done_reg)
        else $error("exec not followed by result beat");

    a_no_back_exec : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> !cmd.exec)
        else $error("exec on two cycles in a row");

    a_grant_running : assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && get_ok_reg && ({1'b0, store_q} < 9'(ID_COUNT)))
        |=> running_reg[$past(store_q[IW-1:0])])
        else $error("granted process not marked running");

    a_put_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (req_reg == REQ_PUT) && ({1'b0, id_reg} < 9'(ID_COUNT)))
        |=> !running_reg[$past(id_reg[IW-1:0])])
        else $error("put did not clear running mark");

    a_grant_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != ST_OK)) |-> (granted_id == 8'd0 && granted_level == 8'd0))
        else $error("granted fields not zero on failed request");
`endif

endmodule

/* rtl/core/strict_priority_multilevel_queue.sv */
// top level of the strict priority multilevel queue
// depends on spmlq_pkg, spmlq_ctrl and spmlq_dp
module strict_priority_multilevel_queue #(
    parameter int NUM_LEVELS  = 140,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_COUNT    = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] req_type,
    input  logic [7:0] proc_id,
    input  logic [7:0] level,
    output logic       done,
    output logic [7:0] granted_id,
    output logic [7:0] granted_level,
    output logic [1:0] status
);
    // a request is taken when start is high and busy low; busy then stays high while the
    // level's head/count memory and the fifo store are accessed, and the result beat
    // appears in the cycle after that, with done high for that single cycle. the
    // receiver cannot stall, so every result must be captured on its done cycle. a new
    // request can be taken in the cycle done is shown, but not while the last one is
    // still accessing the head/count memory and the fifo store. no clearing pass after reset.
    import spmlq_pkg::*;

    spmlq_cmd_t cmd;

    spmlq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    spmlq_dp #(
        .NUM_LEVELS  (NUM_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_COUNT    (ID_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .req_type      (req_type),
        .proc_id       (proc_id),
        .level         (level),
        .done          (done),
        .granted_id    (granted_id),
        .granted_level (granted_level),
        .status        (status)
    );

endmodule
